// ===== src/pidpi_pkg.sv =====
// shared types, constants and arithmetic helpers for the pid controller
package pidpi_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int GAIN_W     = 32;
  localparam int COEF_W     = GAIN_W + 3;
  localparam int PROD_W     = COEF_W + ERR_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int ACC_W      = 56;
  localparam int BOUND_W    = 16;
  localparam int CLAMP_W    = BOUND_W + FRAC_W;
  localparam int OUT_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 2 * SAMPLE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_POS = 2'd0,
    MODE_INC = 2'd1,
    MODE_OFF = 2'd2
  } mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOOP_MODE   = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_OUT_MIN     = 3'd4,
    REG_OUT_MAX     = 3'd5,
    REG_INTEG_LIMIT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic        [MODE_W-1:0]  loop_mode;
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain;
    logic signed [GAIN_W-1:0]  deriv_gain;
    logic signed [BOUND_W-1:0] out_min;
    logic signed [BOUND_W-1:0] out_max;
    logic signed [BOUND_W-1:0] integ_limit;
  } cfg_t;

  // saturate a one-bit-grown sum to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = {v[ACC_W], {(ACC_W-1){~v[ACC_W]}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  // lo < x ? (x < hi ? x : hi) : lo, bounds in integer units
  function automatic logic signed [CLAMP_W-1:0] clamp_out(
    input logic signed [ACC_W-1:0]   x,
    input logic signed [BOUND_W-1:0] lo_b,
    input logic signed [BOUND_W-1:0] hi_b
  );
    logic signed [ACC_W-1:0]   lo;
    logic signed [ACC_W-1:0]   hi;
    logic signed [CLAMP_W-1:0] r;
    lo = ACC_W'($signed({lo_b, {FRAC_W{1'b0}}}));
    hi = ACC_W'($signed({hi_b, {FRAC_W{1'b0}}}));
    if (lo < x) begin
      r = (x < hi) ? x[CLAMP_W-1:0] : hi[CLAMP_W-1:0];
    end else begin
      r = lo[CLAMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/pidpi_cfg.sv =====
// configuration register file of the pid controller
module pidpi_cfg
  import pidpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LOOP_MODE:   cfg_d.loop_mode   = cfg_wdata_i[MODE_W-1:0];
        REG_PROP_GAIN:   cfg_d.prop_gain   = $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_INTEG_GAIN:  cfg_d.integ_gain  = $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_DERIV_GAIN:  cfg_d.deriv_gain  = $signed(cfg_wdata_i[GAIN_W-1:0]);
        REG_OUT_MIN:     cfg_d.out_min     = $signed(cfg_wdata_i[BOUND_W-1:0]);
        REG_OUT_MAX:     cfg_d.out_max     = $signed(cfg_wdata_i[BOUND_W-1:0]);
        REG_INTEG_LIMIT: cfg_d.integ_limit = $signed(cfg_wdata_i[BOUND_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_mode   <= MODE_POS;
      cfg_q.prop_gain   <= '0;
      cfg_q.integ_gain  <= '0;
      cfg_q.deriv_gain  <= '0;
      cfg_q.out_min     <= {1'b1, {(BOUND_W-1){1'b0}}};
      cfg_q.out_max     <= {1'b0, {(BOUND_W-1){1'b1}}};
      cfg_q.integ_limit <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/pid_position_incremental.sv =====
// PID controller, position and incremental forms, one sample per beat.
// Each input beat carries a measured sample and a target; the error is target minus
// measured. Position form integrates ki*e (frozen while the integrator sits outside
// the integral limit unless the error pulls it back) and drives (kp+kd)*e - kd*e1 plus
// the integrator; incremental form adds (kp+ki+kd)*e - (kp+2kd)*e1 + kd*e2 to a clamped
// accumulator; mode off drives zero. Gains are signed Q16.16, the output is the floor
// of the clamped value. The pipeline is five stages deep (error, products, sums,
// accumulator, output), and a new beat is taken every cycle unless a blocked output
// beat stalls the pipeline; the accumulator stage sets that rate.
// The user must write registers only while no beat is in flight; the block itself
// does not enforce it.
module pid_position_incremental
  import pidpi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // measured, target
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,  // drive
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;

  pidpi_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic s_accept;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_accept = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: error and history
  logic signed [SAMPLE_W-1:0] meas;
  logic signed [SAMPLE_W-1:0] tgt;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    e1_q, e2_q;
  logic signed [ERR_W-1:0]    s1_e_q, s1_e1_q, s1_e2_q;

  assign meas = $signed(s_axis_tdata[SAMPLE_W-1:0]);
  assign tgt  = $signed(s_axis_tdata[IN_DATA_W-1:SAMPLE_W]);
  assign err  = ERR_W'(tgt) - ERR_W'(meas);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      e2_q <= '0;
    end else if (s_accept) begin
      e1_q <= err;
      e2_q <= e1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_e_q  <= err;
      s1_e1_q <= e1_q;
      s1_e2_q <= e2_q;
    end
  end

  // stage 2: three products, coefficients picked by mode
  logic signed [COEF_W-1:0] kp, ki, kd;
  logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
  logic signed [ERR_W-1:0]  var_c;
  logic signed [PROD_W-1:0] s2_pa_q, s2_pb_q, s2_pc_q;
  logic                     s2_pos_q, s2_neg_q;
  logic                     load2;

  assign kp = COEF_W'(cfg.prop_gain);
  assign ki = COEF_W'(cfg.integ_gain);
  assign kd = COEF_W'(cfg.deriv_gain);

  always_comb begin
    if (cfg.loop_mode == MODE_POS) begin
      coef_a = kp + kd;
      coef_b = -kd;
      coef_c = ki;
      var_c  = s1_e_q;
    end else begin
      coef_a = kp + ki + kd;
      coef_b = -kp - (kd <<< 1);
      coef_c = kd;
      var_c  = s1_e2_q;
    end
  end

  assign load2 = v1_q && rdy2;

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_pa_q  <= PROD_W'(coef_a * PROD_W'(s1_e_q));
      s2_pb_q  <= PROD_W'(coef_b * PROD_W'(s1_e1_q));
      s2_pc_q  <= PROD_W'(coef_c * PROD_W'(var_c));
      s2_pos_q <= !s1_e_q[ERR_W-1] && (s1_e_q != '0);
      s2_neg_q <= s1_e_q[ERR_W-1];
    end
  end

  // stage 3: partial sums
  logic signed [SUM_W-1:0]  s3_pab_q, s3_pabc_q;
  logic signed [PROD_W-1:0] s3_pc_q;
  logic                     s3_pos_q, s3_neg_q;
  logic                     load3;

  assign load3 = v2_q && rdy3;

  always_ff @(posedge clk_i) begin
    if (load3) begin
      s3_pab_q  <= SUM_W'(s2_pa_q) + SUM_W'(s2_pb_q);
      s3_pabc_q <= SUM_W'(s2_pa_q) + SUM_W'(s2_pb_q) + SUM_W'(s2_pc_q);
      s3_pc_q   <= s2_pc_q;
      s3_pos_q  <= s2_pos_q;
      s3_neg_q  <= s2_neg_q;
    end
  end

  // stage 4: accumulator
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SUM_W-1:0]  s4_pab_q;
  logic [BOUND_W:0]         lim_mag;
  logic signed [ACC_W-1:0]  lim;
  logic                     in_band, opposite;
  logic                     load4;

  assign load4   = v3_q && rdy4;
  assign lim_mag = cfg.integ_limit[BOUND_W-1] ? (~{1'b1, cfg.integ_limit}) + 1'b1
                                              : {1'b0, cfg.integ_limit};
  assign lim      = $signed(ACC_W'({lim_mag, {FRAC_W{1'b0}}}));
  assign in_band  = (-lim < acc_q) && (acc_q < lim);
  assign opposite = (acc_q[ACC_W-1] && s3_pos_q)
                 || (!acc_q[ACC_W-1] && (acc_q != '0) && s3_neg_q);

  always_comb begin
    acc_d = acc_q;
    case (cfg.loop_mode)
      MODE_POS: begin
        if (in_band || opposite) begin
          acc_d = sat_acc((ACC_W+1)'(acc_q) + (ACC_W+1)'(s3_pc_q));
        end
      end
      MODE_INC: begin
        acc_d = ACC_W'(clamp_out(sat_acc((ACC_W+1)'(acc_q) + (ACC_W+1)'(s3_pabc_q)),
                                 cfg.out_min, cfg.out_max));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (load4) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load4) begin
      s4_pab_q <= s3_pab_q;
    end
  end

  // stage 5: output
  logic signed [CLAMP_W-1:0] pos_clamp;
  logic signed [OUT_W-1:0]   drive_d, drive_q;
  logic                      load5;

  assign load5 = v4_q && rdy5;
  assign pos_clamp = clamp_out(sat_acc((ACC_W+1)'(acc_q) + (ACC_W+1)'(s4_pab_q)),
                               cfg.out_min, cfg.out_max);

  always_comb begin
    case (cfg.loop_mode)
      MODE_POS: drive_d = pos_clamp[CLAMP_W-1:FRAC_W];
      MODE_INC: drive_d = acc_q[CLAMP_W-1:FRAC_W];
      default:  drive_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load5) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = drive_q;

`ifndef ASSERT_OFF
  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked output beat");

  a_acc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load4 |=> $stable(acc_q))
    else $error("accumulator changed without a beat entering it");

  a_history_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (e2_q == $past(e1_q)))
    else $error("error history did not shift");

  a_off_drives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load5 && (cfg.loop_mode != MODE_POS) && (cfg.loop_mode != MODE_INC))
      |=> (m_axis_tdata == '0))
    else $error("mode off gave a nonzero drive");
`endif

endmodule

// ===== verif/tb_pid_position_incremental.sv =====
// Self-checking stream testbench for the position/incremental pid controller
`timescale 1ns / 1ps

module tb_pid_position_incremental;
  import pidpi_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int STUCK_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_PHASES    = 11;
  localparam int RUN_BEATS     = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] target;
    logic signed [SAMPLE_W-1:0] measured;
  } sample_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  sample_t                 sample_q[$];
  logic signed [OUT_W-1:0] drive_exp_q[$];
  int                      err_cnt    = 0;
  int                      stuck_cnt  = 0;
  int                      hold_left  = 0;
  bit                      hold_done  = 1'b0;
  bit                      hold_armed = 1'b0;
  bit                      steady     = 1'b0;

  // controller state and register copies
  mode_e                     mdl_mode;
  logic signed [GAIN_W-1:0]  mdl_kp;
  logic signed [GAIN_W-1:0]  mdl_ki;
  logic signed [GAIN_W-1:0]  mdl_kd;
  logic signed [BOUND_W-1:0] mdl_lo;
  logic signed [BOUND_W-1:0] mdl_hi;
  logic signed [BOUND_W-1:0] mdl_limit;
  logic signed [ACC_W-1:0]   mdl_acc;
  logic signed [ERR_W-1:0]   mdl_e1;
  logic signed [ERR_W-1:0]   mdl_e2;

  pid_position_incremental i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint cap_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p > (longint'(1) <<< 56)) p = longint'(1) <<< 56;
    if (p < -(longint'(1) <<< 56)) p = -(longint'(1) <<< 56);
    return p;
  endfunction

  function automatic longint sat56(longint v);
    if (v > (longint'(1) <<< 55) - 1) return (longint'(1) <<< 55) - 1;
    if (v < -(longint'(1) <<< 55)) return -(longint'(1) <<< 55);
    return v;
  endfunction

  function automatic longint clamp_q(longint x);
    longint lo;
    longint hi;
    lo = longint'(mdl_lo) * 65536;
    hi = longint'(mdl_hi) * 65536;
    return (lo < x) ? ((x < hi) ? x : hi) : lo;
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_drive(sample_t smp);
    longint e;
    longint acc;
    longint lim;
    longint sum;
    longint q;
    logic   in_band;
    logic   pulls_back;
    e   = longint'(smp.target) - longint'(smp.measured);
    acc = longint'(mdl_acc);
    q   = 0;
    case (mdl_mode)
      MODE_POS: begin
        lim = longint'(mdl_limit) * 65536;
        if (lim < 0) lim = -lim;
        in_band    = (-lim < acc) && (acc < lim);
        pulls_back = (acc < 0 && e > 0) || (acc > 0 && e < 0);
        if (in_band || pulls_back) acc = sat56(acc + cap_mul(longint'(mdl_ki), e));
        sum = cap_mul(longint'(mdl_kp) + longint'(mdl_kd), e)
            + cap_mul(-longint'(mdl_kd), longint'(mdl_e1)) + acc;
        q = clamp_q(sat56(sum));
      end
      MODE_INC: begin
        sum = acc + cap_mul(longint'(mdl_kp) + longint'(mdl_ki) + longint'(mdl_kd), e)
            + cap_mul(-longint'(mdl_kp) - 2 * longint'(mdl_kd), longint'(mdl_e1))
            + cap_mul(longint'(mdl_kd), longint'(mdl_e2));
        acc = sat56(clamp_q(sat56(sum)));
        q   = acc;
      end
      default: q = 0;
    endcase
    mdl_acc = acc;
    mdl_e2  = mdl_e1;
    mdl_e1  = e;
    return OUT_W'(q >>> FRAC_W);
  endfunction

  // driver: offers queued samples, predicts each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    logic take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) drive_exp_q.push_back(predict_drive(sample_t'(s_axis_tdata)));
      if (!s_axis_tvalid || take) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_armed && !hold_done && drive_exp_q.size() >= 3) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy       = 1'b0;
      end else begin
        rdy = steady || $urandom_range(99) >= 6;
      end
      m_axis_tready <= rdy;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic signed [OUT_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_exp_q.size() == 0) begin
        $error("drive beat %0d with nothing expected", $signed(m_axis_tdata));
        err_cnt++;
      end else begin
        want = drive_exp_q.pop_front();
        if (m_axis_tdata !== want) begin
          $error("drive mismatch: expected %0d, actual %0d", want, $signed(m_axis_tdata));
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cnt = 0;
    end else begin
      stuck_cnt++;
    end
    if (stuck_cnt == STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic settle();
    while (sample_q.size() != 0 || s_axis_tvalid || drive_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_LOOP_MODE:   mdl_mode  = mode_e'(val[MODE_W-1:0]);
      REG_PROP_GAIN:   mdl_kp    = val;
      REG_INTEG_GAIN:  mdl_ki    = val;
      REG_DERIV_GAIN:  mdl_kd    = val;
      REG_OUT_MIN:     mdl_lo    = val[BOUND_W-1:0];
      REG_OUT_MAX:     mdl_hi    = val[BOUND_W-1:0];
      REG_INTEG_LIMIT: mdl_limit = val[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(mode_e m, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                           logic [GAIN_W-1:0] kd, logic [BOUND_W-1:0] lo,
                           logic [BOUND_W-1:0] hi, logic [BOUND_W-1:0] lim);
    settle();
    set_reg(REG_LOOP_MODE, CFG_DATA_W'(m));
    set_reg(REG_PROP_GAIN, kp);
    set_reg(REG_INTEG_GAIN, ki);
    set_reg(REG_DERIV_GAIN, kd);
    set_reg(REG_OUT_MIN, {{(CFG_DATA_W-BOUND_W){lo[BOUND_W-1]}}, lo});
    set_reg(REG_OUT_MAX, {{(CFG_DATA_W-BOUND_W){hi[BOUND_W-1]}}, hi});
    set_reg(REG_INTEG_LIMIT, {{(CFG_DATA_W-BOUND_W){lim[BOUND_W-1]}}, lim});
  endtask

  function automatic void push_sample(int meas, int tgt);
    sample_q.push_back(sample_t'{target: SAMPLE_W'(tgt), measured: SAMPLE_W'(meas)});
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return GAIN_W'(int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000);
    endcase
  endfunction

  task automatic random_settings();
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    case ($urandom_range(4))
      0: begin
        lo = BOUND_W'($urandom());
        hi = BOUND_W'($urandom());
      end
      1: begin
        lo = 16'h8000;
        hi = 16'h7FFF;
      end
      default: begin
        lo = BOUND_W'(-int'($urandom_range(1, 3000)));
        hi = BOUND_W'($urandom_range(1, 3000));
      end
    endcase
    apply_cfg(mode_e'(MODE_W'($urandom_range(2))), rand_gain(), rand_gain(), rand_gain(),
              lo, hi, BOUND_W'($urandom()));
  endtask

  // step responses toward held set points, mixed with raw noise beats
  function automatic void random_run(int n);
    int setpt;
    int meas;
    int left;
    setpt = 0;
    meas  = int'($urandom_range(0, 4000)) - 2000;
    left  = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        sample_q.push_back(sample_t'($urandom()));
      end else begin
        if (left == 0) begin
          setpt = int'($urandom_range(0, 4000)) - 2000;
          left  = $urandom_range(3, 20);
        end
        left--;
        meas = meas + (setpt - meas) / 4 + int'($urandom_range(0, 20)) - 10;
        push_sample(meas, setpt);
      end
    end
  endfunction

  initial begin
    mdl_mode  = MODE_POS;
    mdl_kp    = '0;
    mdl_ki    = '0;
    mdl_kd    = '0;
    mdl_lo    = 16'sh8000;
    mdl_hi    = 16'sh7FFF;
    mdl_limit = '0;
    mdl_acc   = '0;
    mdl_e1    = '0;
    mdl_e2    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // position form: extremes, integrator freeze at the limit, pull-back
    apply_cfg(MODE_POS, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000,
              16'h8000, 16'h7FFF, BOUND_W'(-50));
    push_sample(0, 0);
    push_sample(-32768, 32767);
    push_sample(32767, -32768);
    push_sample(0, 100);
    push_sample(0, 100);
    push_sample(0, 100);
    push_sample(200, 0);
    push_sample(5, 5);

    // incremental form with extreme gains and a narrow window
    apply_cfg(MODE_INC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              BOUND_W'(-100), BOUND_W'(200), 16'h0000);
    push_sample(0, 1);
    push_sample(1, 0);
    push_sample(-32768, 32767);
    push_sample(0, 0);
    push_sample(32767, -32768);
    push_sample(3, -3);

    // off, then position form with crossed output bounds
    apply_cfg(MODE_OFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              BOUND_W'(50), BOUND_W'(-50), 16'h7FFF);
    push_sample(0, 10);
    push_sample(10, 0);
    push_sample(-7, 7);
    apply_cfg(MODE_POS, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              BOUND_W'(50), BOUND_W'(-50), 16'h8000);
    push_sample(0, 10);
    push_sample(0, 100);
    push_sample(100, 0);
    push_sample(0, -1000);

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      random_settings();
      hold_armed = (ph == 2);
      steady     = (ph == 5);
      random_run(RUN_BEATS);
    end

    settle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
